### design/otr_pkg.sv
package otr_pkg;

  // command and line byte values
  localparam logic [7:0] RESET_BYTE = 8'hF0;
  localparam logic [7:0] SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CONVERT_T  = 8'h44;
  localparam logic [7:0] READ_PAD   = 8'hBE;
  localparam logic [7:0] READ_SLOT  = 8'hFF;
  localparam logic [7:0] LINE_ZERO  = 8'h00;

  // beat index of the trailing read slot after the two command bytes
  localparam logic [4:0] CMD_SLOT_IDX = 5'd16;
  localparam logic [4:0] CMD_LAST_IDX = 5'd15;

  // job queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    MODE_CONVERT = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RX      = 2'd2
  } otr_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESENCE = 2'd1,
    ST_SLOTS    = 2'd2
  } otr_stage_e;

  typedef enum logic [1:0] {
    JOB_RESET = 2'd0,
    JOB_CMD   = 2'd1,
    JOB_SLOT  = 2'd2,
    JOB_TEMP  = 2'd3
  } otr_op_e;

  typedef struct packed {
    otr_op_e     op;
    logic        reading;
    logic        presence;
    logic [15:0] word;
  } otr_job_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        slow_baud;
    logic [15:0] temperature_raw;
    logic        presence;
    logic        last;
  } otr_beat_t;

endpackage

### design/onewire_uart_temp_reader.sv
// an input beat's job is stored in the job queue; its result beats are registered on m_axis
// throughput: one input beat per cycle while the 4-entry job queue has room; one result
//   beat per cycle out while ready is high; a presence echo holds it for 16 or 17 beats
// reset: rst_ni is asynchronous, active low; clears the transaction stage, the job queue
//   and the output valid; presence reads 0 until the first presence echo
module onewire_uart_temp_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,  // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] tx_byte, [8] slow_baud,
                                     // [24:9] temperature_raw, [25] presence, rest zero
  output logic        m_axis_tuser,  // [0] kind
  output logic        m_axis_tlast
);

  logic               in_fire;
  logic               push, pop, empty, full;
  otr_pkg::otr_job_t  job, head;
  otr_pkg::otr_beat_t beat;

  // input side stalls only when the job queue is full
  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // front: tracks the 1-wire transaction and turns each beat into at most one job
  otr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .mode_i    (s_axis_tuser),
    .rx_byte_i (s_axis_tdata),
    .push_o    (push),
    .job_o     (job)
  );

  // short queue between classification and beat generation
  otr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  // back: expands each job into line bytes or the temperature word
  otr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .beat_o      (beat)
  );

  // pack result fields from bit 0 up
  assign m_axis_tdata = {6'd0, beat.presence, beat.temperature_raw, beat.slow_baud,
                         beat.tx_byte};
  assign m_axis_tuser = beat.kind;
  assign m_axis_tlast = beat.last;

endmodule

### design/otr_front.sv
module otr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        rx_byte_i,
  output logic              push_o,
  output otr_pkg::otr_job_t job_o
);

  otr_pkg::otr_stage_e stage_q, stage_d;
  logic        reading_q, reading_d;
  logic [4:0]  slot_q, slot_d;
  logic [15:0] word_q, word_d;
  logic        pres_q, pres_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q   <= otr_pkg::ST_IDLE;
      reading_q <= 1'b0;
      slot_q    <= '0;
      word_q    <= '0;
      pres_q    <= 1'b0;
    end else begin
      stage_q   <= stage_d;
      reading_q <= reading_d;
      slot_q    <= slot_d;
      word_q    <= word_d;
      pres_q    <= pres_d;
    end
  end

  always_comb begin
    logic [15:0] word_n;
    logic [4:0]  slot_n;
    logic        pres_n;
    stage_d   = stage_q;
    reading_d = reading_q;
    slot_d    = slot_q;
    word_d    = word_q;
    pres_d    = pres_q;
    push_o    = 1'b0;
    job_o     = '{op: otr_pkg::JOB_RESET, reading: reading_q, presence: pres_q, word: '0};
    word_n    = {rx_byte_i[0], word_q[15:1]};
    slot_n    = slot_q + 5'd1;
    pres_n    = (rx_byte_i != otr_pkg::RESET_BYTE);
    if (in_fire_i) begin
      unique case (otr_pkg::otr_mode_e'(mode_i))
        otr_pkg::MODE_CONVERT, otr_pkg::MODE_READ: begin
          // commands only start from idle, busy ones are dropped
          if (stage_q != otr_pkg::ST_PRESENCE && stage_q != otr_pkg::ST_SLOTS) begin
            reading_d = mode_i[0];
            slot_d    = '0;
            word_d    = '0;
            stage_d   = otr_pkg::ST_PRESENCE;
            push_o    = 1'b1;
            job_o.op  = otr_pkg::JOB_RESET;
          end
        end
        otr_pkg::MODE_RX: begin
          if (stage_q == otr_pkg::ST_PRESENCE) begin
            pres_d        = pres_n;
            push_o        = 1'b1;
            job_o.op      = otr_pkg::JOB_CMD;
            job_o.presence = pres_n;
            if (reading_q) begin
              slot_d  = '0;
              word_d  = '0;
              stage_d = otr_pkg::ST_SLOTS;
            end else begin
              stage_d = otr_pkg::ST_IDLE;
            end
          end else if (stage_q == otr_pkg::ST_SLOTS) begin
            word_d = word_n;
            push_o = 1'b1;
            if (slot_n[4]) begin
              slot_d     = '0;
              stage_d    = otr_pkg::ST_IDLE;
              job_o.op   = otr_pkg::JOB_TEMP;
              job_o.word = word_n;
            end else begin
              slot_d   = slot_n;
              job_o.op = otr_pkg::JOB_SLOT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/otr_queue.sv
module otr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  otr_pkg::otr_job_t job_i,
  input  logic              pop_i,
  output otr_pkg::otr_job_t head_o,
  output logic              empty_o,
  output logic              full_o
);

  otr_pkg::otr_job_t mem_q [otr_pkg::QDEPTH];
  logic [otr_pkg::QAW-1:0] wr_q, rd_q;
  logic [otr_pkg::QAW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (otr_pkg::QAW+1)'(otr_pkg::QDEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### design/otr_back.sv
module otr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  otr_pkg::otr_job_t  head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output otr_pkg::otr_beat_t beat_o
);

  logic               valid_q;
  otr_pkg::otr_beat_t beat_q, beat_d;
  logic [4:0]         idx_q;
  logic               load, fire;
  logic [7:0]         cmd_byte;
  logic               cmd_bit;

  assign load        = !valid_q || out_ready_i;
  assign fire        = load && !empty_i;
  assign pop_o       = fire && beat_d.last;
  assign out_valid_o = valid_q;
  assign beat_o      = beat_q;

  // second command byte depends on the transaction kind
  assign cmd_byte = head_i.reading ? otr_pkg::READ_PAD : otr_pkg::CONVERT_T;
  assign cmd_bit  = idx_q[3] ? cmd_byte[idx_q[2:0]] : otr_pkg::SKIP_ROM[idx_q[2:0]];

  always_comb begin
    beat_d = '{kind: 1'b0, tx_byte: otr_pkg::LINE_ZERO, slow_baud: 1'b0,
               temperature_raw: '0, presence: head_i.presence, last: 1'b1};
    unique case (head_i.op)
      otr_pkg::JOB_RESET: begin
        beat_d.tx_byte   = otr_pkg::RESET_BYTE;
        beat_d.slow_baud = 1'b1;
      end
      otr_pkg::JOB_CMD: begin
        if (idx_q[4]) begin
          beat_d.tx_byte = otr_pkg::READ_SLOT;
        end else begin
          beat_d.tx_byte = cmd_bit ? otr_pkg::READ_SLOT : otr_pkg::LINE_ZERO;
        end
        beat_d.last = head_i.reading ? (idx_q == otr_pkg::CMD_SLOT_IDX)
                                     : (idx_q == otr_pkg::CMD_LAST_IDX);
      end
      otr_pkg::JOB_SLOT: begin
        beat_d.tx_byte = otr_pkg::READ_SLOT;
      end
      otr_pkg::JOB_TEMP: begin
        beat_d.kind            = 1'b1;
        beat_d.temperature_raw = head_i.word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
      end
      if (pop_o) begin
        idx_q <= '0;
      end else if (fire) begin
        idx_q <= idx_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      beat_q <= beat_d;
    end
  end

endmodule

### design/otr_checker.sv
module otr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result beat changed under stall");

  // temperature result is alone and carries no line byte
  a_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[8:0] == 9'd0)
    else $error("bad temperature beat");

  // slow baud only for the single reset byte
  a_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |->
      m_axis_tdata[7:0] == otr_pkg::RESET_BYTE && m_axis_tlast && !m_axis_tuser)
    else $error("slow baud on wrong beat");

  // line beats carry no temperature and padding stays zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:26] == 6'd0
      && (m_axis_tuser || m_axis_tdata[24:9] == 16'd0))
    else $error("stray bits in result beat");

endmodule

bind onewire_uart_temp_reader otr_checker u_otr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import otr_pkg::*;

  // mode code the block has no meaning for
  localparam logic [1:0] MODE_NONE = 2'd3;
  // line byte that writes a one bit
  localparam logic [7:0] LINE_ONE  = 8'hFF;

  localparam int ITEM_TARGET = 430;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 16;

  // temperature reader model plus the queue of result beats still owed
  class temp_reader_sb;
    otr_stage_e stage;
    bit         reading;
    bit [4:0]   slot_count;
    bit [15:0]  shift_word;
    bit         presence_seen;
    otr_beat_t  pending_beats[$];
    int         mismatch_count;

    function new();
      stage          = ST_IDLE;
      reading        = 1'b0;
      slot_count     = '0;
      shift_word     = '0;
      presence_seen  = 1'b0;
      mismatch_count = 0;
    endfunction

    function void add_beat(bit kind, logic [7:0] tx, bit slow, logic [15:0] temp, bit last);
      otr_beat_t b;
      b.kind            = kind;
      b.tx_byte         = tx;
      b.slow_baud       = slow;
      b.temperature_raw = temp;
      b.presence        = presence_seen;
      b.last            = last;
      pending_beats.push_back(b);
    endfunction

    // advances the sequencer by one accepted input beat, returns beats owed
    function int note_input(logic [1:0] mode, logic [7:0] rx);
      logic [15:0] cmd_bits;
      if (mode == MODE_CONVERT || mode == MODE_READ) begin
        if (stage != ST_IDLE) return 0;  // command while busy
        reading    = (mode == MODE_READ);
        slot_count = '0;
        shift_word = '0;
        stage      = ST_PRESENCE;
        add_beat(1'b0, RESET_BYTE, 1'b1, 16'h0000, 1'b1);
        return 1;
      end
      if (mode != MODE_RX) return 0;
      if (stage == ST_PRESENCE) begin
        presence_seen = (rx != RESET_BYTE);
        // skip rom then the function byte, lsb first
        cmd_bits = {(reading ? READ_PAD : CONVERT_T), SKIP_ROM};
        for (int j = 0; j < 16; j++)
          add_beat(1'b0, cmd_bits[j] ? LINE_ONE : LINE_ZERO, 1'b0, 16'h0000,
                   !reading && j == 15);
        if (reading) begin
          add_beat(1'b0, READ_SLOT, 1'b0, 16'h0000, 1'b1);
          slot_count = '0;
          shift_word = '0;
          stage      = ST_SLOTS;
          return 17;
        end
        stage = ST_IDLE;
        return 16;
      end
      if (stage == ST_SLOTS) begin
        shift_word = {rx[0], shift_word[15:1]};
        slot_count++;
        if (slot_count >= 5'd16) begin
          stage      = ST_IDLE;
          slot_count = '0;
          add_beat(1'b1, 8'h00, 1'b0, shift_word, 1'b1);
          return 1;
        end
        add_beat(1'b0, READ_SLOT, 1'b0, 16'h0000, 1'b1);
        return 1;
      end
      return 0;  // stray byte while idle
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(logic [31:0] tdata, logic kind, logic last);
      otr_beat_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat expected none actual tdata %h kind %0b last %0b",
                 $time, tdata, kind, last);
        mismatch_count++;
        return;
      end
      want = pending_beats.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("tx_byte", want.tx_byte, tdata[7:0]);
      compare_field("slow_baud", want.slow_baud, tdata[8]);
      compare_field("temperature_raw", want.temperature_raw, tdata[24:9]);
      compare_field("presence", want.presence, tdata[25]);
      compare_field("tdata pad", 0, tdata[31:26]);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] tx_byte, [8] slow_baud, [24:9] temperature_raw,
                               // [25] presence, rest zero
  logic        m_axis_tuser;   // [0] kind
  logic        m_axis_tlast;

  temp_reader_sb sb;
  int            items_done;
  int            burst_left;
  bit            hold_req;

  onewire_uart_temp_reader dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // offer one beat, wait for it to be taken, then maybe open a gap
  task automatic send_beat(input logic [1:0] mode, input logic [7:0] rx);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    if (sb.note_input(mode, rx) > 0) items_done++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // stop offering until every owed beat has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_beats.size() != 0);
  endtask

  // command, presence echo, and for a read up to sixteen slot echoes
  task automatic run_transaction(input bit is_read);
    logic [15:0] word;
    logic [7:0]  echo;
    int          slots;
    case ($urandom_range(0, 7))
      0:       word = 16'h0000;
      1:       word = 16'hFFFF;
      default: word = 16'($urandom);
    endcase
    // now and then the read stops short and later bytes finish it
    slots = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 16;
    send_beat(is_read ? MODE_READ : MODE_CONVERT, 8'($urandom));
    if ($urandom_range(0, 7) == 0) send_beat(2'($urandom_range(0, 1)), 8'($urandom));
    echo = ($urandom_range(0, 2) == 0) ? RESET_BYTE : 8'($urandom);
    send_beat(MODE_RX, echo);
    if (is_read) begin
      for (int j = 0; j < slots; j++) begin
        if ($urandom_range(0, 15) == 0) send_beat(2'($urandom_range(0, 1)) | MODE_NONE &
                                                  {2{1'($urandom_range(0, 1))}}, 8'($urandom));
        send_beat(MODE_RX, (8'($urandom) & 8'hFE) | {7'd0, word[j]});
      end
    end
  endtask

  // receiver: a random ready pattern, plus one long hold-off on request
  initial begin
    int style;
    int style_left;
    bit hold_done;
    style          = 0;
    style_left     = 0;
    hold_done      = 1'b0;
    m_axis_tready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= (style_left % 5 < 2);
        endcase
      end
    end
  end

  // every accepted result beat goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  initial begin
    int pick;
    int next_pause;
    bit held;
    sb            = new();
    items_done    = 0;
    burst_left    = 0;
    hold_req      = 1'b0;
    held          = 1'b0;
    next_pause    = 150;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = MODE_CONVERT;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray bytes while idle and the unused mode
    send_beat(MODE_RX, 8'h00);
    send_beat(MODE_RX, 8'hFF);
    send_beat(MODE_NONE, 8'hA5);
    // conversion with no presence, commands and unused mode while busy
    send_beat(MODE_CONVERT, 8'h00);
    send_beat(MODE_READ, 8'hFF);
    send_beat(MODE_NONE, 8'h5A);
    send_beat(MODE_RX, RESET_BYTE);
    // read with presence, all-ones word, a command in the middle of the slots
    send_beat(MODE_READ, 8'h00);
    send_beat(MODE_RX, 8'h00);
    for (int j = 0; j < 16; j++) begin
      if (j == 7) send_beat(MODE_CONVERT, 8'h00);
      send_beat(MODE_RX, 8'hFF);
    end
    drain_results();

    while (items_done < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      // one long receiver hold-off while the sender keeps going
      if (!held && items_done > 120) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (pick < 7) begin
        run_transaction(pick < 4);
      end else if ($urandom_range(0, 3) == 0) begin
        send_beat(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        send_beat($urandom_range(0, 1) ? MODE_RX : MODE_NONE, 8'($urandom));
      end
      if (items_done >= next_pause) begin
        drain_results();
        next_pause += 150;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
design/otr_pkg.sv
design/otr_front.sv
design/otr_queue.sv
design/otr_back.sv
design/onewire_uart_temp_reader.sv
design/otr_checker.sv
dv/tb_top.sv
